>>> sv/decimal_seven_segment_digits_macros.svh
// Assertion macros for the decimal seven-segment digit block.
// Used by the top level only; no other dependencies.
`ifndef DECIMAL_SEVEN_SEGMENT_DIGITS_MACROS_SVH
`define DECIMAL_SEVEN_SEGMENT_DIGITS_MACROS_SVH

// same-cycle implication
`define DSSD_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dssd: same-cycle check failed");

// next-cycle implication
`define DSSD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dssd: next-cycle check failed");

`endif

>>> sv/dssd_pkg.sv
// Shared widths, types and the segment lookup for the digit row block.
// No dependencies.
`timescale 1ns / 1ps

package dssd_pkg;

  localparam int NUMBER_W = 32;
  localparam int DIGIT_W  = 4;
  localparam int SEG_W    = 7;
  localparam int POS_W    = 4;
  localparam int CX_W     = 6;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_t;

  // bit k = segment k: top, upper left, upper right, middle, lower left, lower right, bottom
  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h77;
      4'd1:    s = 7'h24;
      4'd2:    s = 7'h5D;
      4'd3:    s = 7'h6D;
      4'd4:    s = 7'h2E;
      4'd5:    s = 7'h6B;
      4'd6:    s = 7'h7B;
      4'd7:    s = 7'h25;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

>>> sv/dssd_in_if.sv
// Input channel: one binary number per word.
// Depends on dssd_pkg.
`timescale 1ns / 1ps

interface dssd_in_if;
  logic                          valid;
  logic                          ready;
  logic [dssd_pkg::NUMBER_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

>>> sv/dssd_out_if.sv
// Output channel: one displayed digit per word.
// Depends on dssd_pkg.
`timescale 1ns / 1ps

interface dssd_out_if;
  logic                               valid;
  logic                               ready;
  logic [dssd_pkg::DIGIT_W-1:0]       digit;
  logic [dssd_pkg::SEG_W-1:0]         segments;
  logic [dssd_pkg::POS_W-1:0]         position;
  logic signed [dssd_pkg::CX_W-1:0]   center_x;
  logic                               last;

  modport source (output valid, output digit, output segments, output position,
                  output center_x, output last, input ready);
  modport sink (input valid, input digit, input segments, input position,
                input center_x, input last, output ready);
endinterface

>>> sv/decimal_seven_segment_digits.sv
// Decimal seven-segment digit row: top level.
// Uses dssd_pkg, dssd_in_if, dssd_out_if, dssd_dabble, dssd_emit and the macros header.
//
// Usage:
//   numbers carries one unsigned binary number per word (low VALUE_WIDTH bits used).
//   digits carries the decimal digits of that number, most significant first,
//   leading zeros dropped (zero gives one digit 0); each word has the digit, its
//   segment mask, its index, its center in quarter units and a last flag.
//   Only the lowest MAX_DIGITS digits are shown.
// Timing (NDIG = decimal digits needed for VALUE_WIDTH bits, 10 by default):
//   the converter takes one bit per cycle; the sequencer then scans the NDIG
//   digits, drops leading ones one per cycle, and sends one digit per cycle when
//   digits.ready does not stall it. A new number is taken once the last digit
//   sits in the output register.
// Reset (rst, synchronous): converter and sequencer go idle, the output register
//   empties; numbers.ready stays low while rst is high.
// Stalls: when digits.ready is low, the current digit holds in the output
//   register and the sequencer waits; no digit is lost or repeated.
`timescale 1ns / 1ps
`include "decimal_seven_segment_digits_macros.svh"

module decimal_seven_segment_digits #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10
) (
  input  logic        clk,
  input  logic        rst,
  dssd_in_if.sink     numbers,
  dssd_out_if.source  digits
);
  import dssd_pkg::*;

  // decimal digits needed for VALUE_WIDTH bits
  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;

  conv_t                   conv;
  logic [NDIG*DIGIT_W-1:0] bcd;
  logic                    emit_busy;
  logic                    start;

  assign numbers.ready = !rst && !(conv.busy || conv.done || emit_busy);
  assign start         = numbers.valid && numbers.ready;

  dssd_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .number (numbers.number),
    .conv   (conv),
    .bcd    (bcd)
  );

  dssd_emit #(
    .NDIG       (NDIG),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (conv.done),
    .bcd    (bcd),
    .busy   (emit_busy),
    .digits (digits)
  );

  `DSSD_ASSERT_NOW(a_accept_idle, clk, rst, start, !conv.busy && !emit_busy)
  `DSSD_ASSERT_NOW(a_done_idle, clk, rst, conv.done, !emit_busy && !conv.busy)
  `DSSD_ASSERT_NEXT(a_done_loads, clk, rst, conv.done, emit_busy)

endmodule

>>> sv/dssd_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on dssd_pkg.
`timescale 1ns / 1ps

module dssd_dabble #(
  parameter int VALUE_WIDTH = 32,
  parameter int NDIG        = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dssd_pkg::NUMBER_W-1:0]   number,
  output dssd_pkg::conv_t                 conv,
  output logic [NDIG*dssd_pkg::DIGIT_W-1:0] bcd
);
  import dssd_pkg::*;

  localparam int IN_W  = (VALUE_WIDTH < NUMBER_W) ? VALUE_WIDTH : NUMBER_W;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int BCD_W = NDIG * DIGIT_W;

  logic [VALUE_WIDTH-1:0] shreg;
  logic [CNT_W-1:0]       cnt;
  logic [BCD_W-1:0]       corr;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        corr[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        corr[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv <= '0;
      cnt  <= '0;
    end else begin
      conv.done <= conv.busy && (cnt == CNT_W'(1));
      if (start) begin
        conv.busy <= 1'b1;
        cnt       <= CNT_W'(VALUE_WIDTH);
      end else if (conv.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          conv.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= VALUE_WIDTH'(number[IN_W-1:0]);
      bcd   <= '0;
    end else if (conv.busy) begin
      shreg <= shreg << 1;
      bcd   <= {corr[BCD_W-2:0], shreg[VALUE_WIDTH-1]};
    end
  end

endmodule

>>> sv/dssd_emit.sv
// Digit sequencer: drops leading zeros and digits above the shown window one per cycle,
// then sends one digit per word with segments, index and centre. Depends on dssd_pkg.
`timescale 1ns / 1ps

module dssd_emit #(
  parameter int NDIG       = 10,
  parameter int MAX_DIGITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [NDIG*dssd_pkg::DIGIT_W-1:0] bcd,
  output logic                              busy,
  dssd_out_if.source                        digits
);
  import dssd_pkg::*;

  localparam int SHOW  = (NDIG < MAX_DIGITS) ? NDIG : MAX_DIGITS;
  localparam int SH_W  = NDIG * DIGIT_W;
  localparam int CNT_W = $clog2(NDIG + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [SH_W-1:0]  dig;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] pos;
  logic [CX_W-1:0]  cx;
  logic [CX_W-1:0]  span;
  logic             hit;
  logic             drop;
  digit_t           top;

  assign top  = dig[SH_W-1 -: DIGIT_W];
  assign span = CX_W'(cnt - CNT_W'(1));
  assign busy = (state != ST_IDLE);
  // digits above the shown window always go; a nonzero one among them stops suppression
  assign drop = (cnt > CNT_W'(SHOW)) || (cnt > CNT_W'(1) && top == '0 && !hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      digits.valid <= 1'b0;
    end else begin
      if (digits.ready && state != ST_EMIT) begin
        digits.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (load) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!drop) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!digits.valid || digits.ready) begin
            digits.valid <= 1'b1;
            if (cnt == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (load) begin
          dig <= bcd;
          cnt <= CNT_W'(NDIG);
          hit <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (drop) begin
          dig <= dig << DIGIT_W;
          cnt <= cnt - CNT_W'(1);
          hit <= hit || (top != '0);
        end else begin
          pos <= '0;
          cx  <= -(span + (span << 1));
        end
      end
      ST_EMIT: begin
        if (!digits.valid || digits.ready) begin
          digits.digit    <= top;
          digits.segments <= seg_of(top);
          digits.position <= pos;
          digits.center_x <= cx;
          digits.last     <= (cnt == CNT_W'(1));
          dig             <= dig << DIGIT_W;
          cnt             <= cnt - CNT_W'(1);
          pos             <= pos + POS_W'(1);
          cx              <= cx + CX_W'(6);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> bench/decimal_seven_segment_digits_test.sv
// Testbench for decimal_seven_segment_digits: numbers in, one word per decimal digit out.
// A scoreboard class predicts each digit row; uses dssd_in_if, dssd_out_if and the block.
`timescale 1ns / 1ps

module decimal_seven_segment_digits_test;

  localparam int          MAX_SHOWN    = 10;
  localparam int          RANDOM_ITEMS = 220;
  localparam int          LONG_HOLD    = 400;
  localparam int          DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          N_DIRECTED   = 20;

  localparam logic [31:0] DIRECTED [N_DIRECTED] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101,
    32'd1234567890, 32'd1000000000, 32'd1000000001, 32'd999999999,
    32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000, 32'h7FFFFFFF,
    32'hAAAAAAAA, 32'h55555555, 32'd5, 32'd86420, 32'd7
  };

  typedef struct packed {
    logic [3:0]        digit;
    logic [6:0]        segments;
    logic [3:0]        position;
    logic signed [5:0] center_x;
    logic              last;
  } digit_word_t;

  class digit_row_scoreboard;
    digit_word_t pending_digits[$];
    int unsigned error_count;

    function new();
      error_count = 0;
    endfunction

    function int unsigned pending();
      return pending_digits.size();
    endfunction

    function logic [6:0] segments_for(input logic [3:0] d);
      case (d)
        4'd0:    return 7'h77;
        4'd1:    return 7'h24;
        4'd2:    return 7'h5D;
        4'd3:    return 7'h6D;
        4'd4:    return 7'h2E;
        4'd5:    return 7'h6B;
        4'd6:    return 7'h7B;
        4'd7:    return 7'h25;
        4'd8:    return 7'h7F;
        4'd9:    return 7'h6F;
        default: return 7'h00;
      endcase
    endfunction

    // decimal digits, most significant first; zero shows as a lone 0
    function void note_number(input logic [31:0] number);
      logic [3:0]  low_first [MAX_SHOWN];
      logic [31:0] v;
      int          count;
      int          k;
      int          cx;
      digit_word_t w;
      v = number;
      count = 0;
      while (v != 0 && count < MAX_SHOWN) begin
        low_first[count] = 4'(v % 10);
        v = v / 10;
        count++;
      end
      if (count == 0) begin
        low_first[0] = 4'd0;
        count = 1;
      end
      for (k = 0; k < count; k++) begin
        cx = 6 * k - 3 * (count - 1);
        w.digit    = low_first[count - 1 - k];
        w.segments = segments_for(w.digit);
        w.position = 4'(k);
        w.center_x = cx[5:0];
        w.last     = (k == count - 1);
        pending_digits = {pending_digits, w};
      end
    endfunction

    function void check_digit(input digit_word_t got);
      digit_word_t exp;
      if (pending_digits.size() == 0) begin
        $error("unexpected digit word: digit %0d position %0d", got.digit, got.position);
        error_count++;
        return;
      end
      exp = pending_digits.pop_front();
      if (got.digit !== exp.digit) begin
        $error("digit: expected %0d, actual %0d", exp.digit, got.digit);
        error_count++;
      end
      if (got.segments !== exp.segments) begin
        $error("segments: expected 0x%02h, actual 0x%02h", exp.segments, got.segments);
        error_count++;
      end
      if (got.position !== exp.position) begin
        $error("position: expected %0d, actual %0d", exp.position, got.position);
        error_count++;
      end
      if (got.center_x !== exp.center_x) begin
        $error("center_x: expected %0d, actual %0d", exp.center_x, got.center_x);
        error_count++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, actual %0d", exp.last, got.last);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   hold_request = 1'b0;

  digit_row_scoreboard board;

  dssd_in_if  numbers_if ();
  dssd_out_if digits_if ();

  decimal_seven_segment_digits u_top (
    .clk     (clk),
    .rst     (rst),
    .numbers (numbers_if),
    .digits  (digits_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] pick_number();
    logic [63:0] p;
    p = 64'd1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 99);
      3: begin
        repeat ($urandom_range(1, 9)) p = p * 10;
        return 32'(p + $urandom_range(0, 2) - 1);
      end
      4: return 32'hFFFFFFFF - $urandom_range(0, 1000);
      default: return $urandom >> $urandom_range(20, 31);
    endcase
  endfunction

  task automatic send_word(input logic [31:0] n);
    numbers_if.valid  <= 1'b1;
    numbers_if.number <= n;
    do @(posedge clk); while (!numbers_if.ready);
    board.note_number(n);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // result side: rotating stall pattern, plus one long hold-off on request
  initial begin
    int unsigned rx_cycle;
    int          hold_left;
    bit          hold_done;
    rx_cycle = 0;
    hold_left = 0;
    hold_done = 1'b0;
    digits_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_request && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        digits_if.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: digits_if.ready <= 1'b1;
          1: digits_if.ready <= ($urandom_range(0, 3) != 0);
          2: digits_if.ready <= ($urandom_range(0, 3) == 0);
          default: digits_if.ready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && digits_if.valid && digits_if.ready) begin
      board.check_digit(digit_word_t'{
        digit:    digits_if.digit,
        segments: digits_if.segments,
        position: digits_if.position,
        center_x: digits_if.center_x,
        last:     digits_if.last
      });
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int i;
    int burst_left;
    board = new();
    numbers_if.valid = 1'b0;
    numbers_if.number = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) send_word(DIRECTED[i]);
    numbers_if.valid <= 1'b0;
    wait_drained();

    burst_left = $urandom_range(1, 12);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 70 || i == 170) begin
        numbers_if.valid <= 1'b0;
        wait_drained();
      end
      if (i == 120) hold_request = 1'b1;
      send_word(pick_number());
      if (burst_left == 0) begin
        numbers_if.valid  <= 1'b0;
        numbers_if.number <= $urandom;
        repeat ($urandom_range(1, 60)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
    numbers_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.error_count == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> decimal_seven_segment_digits.f
+incdir+sv
sv/dssd_pkg.sv
sv/dssd_in_if.sv
sv/dssd_out_if.sv
sv/dssd_dabble.sv
sv/dssd_emit.sv
sv/decimal_seven_segment_digits.sv
bench/decimal_seven_segment_digits_test.sv
